FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define AJPE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ajpe assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define AJPE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ajpe assertion failed");

`endif

FILE: hdl/ajpe_pkg.sv
`timescale 1ns / 1ps

package ajpe_pkg;

	localparam int IN_W   = 128;
	localparam int USER_W = 2;
	localparam int OUT_W  = 16;

	localparam int FRAME_BYTES = 12;
	localparam logic [3:0] FRAME_END = 4'(FRAME_BYTES);

	// item kinds
	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_PAD   = 2'd2;

	// joy_mode values
	localparam logic [1:0] JOY_DIGITAL = 2'd0;
	localparam logic [1:0] JOY_ANALOG  = 2'd1;
	localparam logic [1:0] JOY_AUTO    = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_JOY_MODE    = 3'd0;
	localparam logic [2:0] CFG_OVL_ENABLE  = 3'd1;
	localparam logic [2:0] CFG_OVL_PORT    = 3'd2;
	localparam logic [2:0] CFG_PORT_ENABLE = 3'd3;
	localparam logic [2:0] CFG_IDLE_LIMIT  = 3'd4;
	localparam logic [2:0] CFG_DETECT_MIN  = 3'd5;
	localparam logic [2:0] CFG_START_DELAY = 3'd6;

	// handshake phases
	localparam logic [3:0] PH_DELAY  = 4'd0;
	localparam logic [3:0] PH_LEAD_A = 4'd1;
	localparam logic [3:0] PH_DATA_A = 4'd2;
	localparam logic [3:0] PH_TAIL_A = 4'd3;
	localparam logic [3:0] PH_LEAD_B = 4'd4;
	localparam logic [3:0] PH_DATA_B = 4'd5;
	localparam logic [3:0] PH_TAIL_B = 4'd6;
	localparam logic [3:0] PH_GAP    = 4'd7;

	localparam logic [7:0] ACK_BIT   = 8'h40;
	localparam logic [7:0] IDLE_BYTE = 8'hDF;
	localparam logic [7:0] SEL_ALL   = 8'hFF;

	// one row per port; frame sources are only used on port 0
	typedef struct packed {
		logic [7:0] sz;
		logic [7:0] sy;
		logic [7:0] sx;
		logic [7:0] btn;
		logic [7:0] pad_high;
		logic [7:0] pad_low;
		logic [7:0] sel;
	} ajpe_row_t;

	localparam int ROW_W = $bits(ajpe_row_t);

	localparam ajpe_row_t ROW_RESET = '{
		sz: 8'h7F, sy: 8'h7F, sx: 8'h7F, btn: 8'h00,
		pad_high: 8'hFF, pad_low: 8'hFF, sel: 8'h00
	};

	// (v + 32768) * 255 / 65535 equals biased / 257: take biased >> 8, step down once if over
	function automatic logic [7:0] scale_axis(input logic [15:0] v);
		logic [15:0] biased;
		logic [7:0]  q0;
		logic [16:0] prod;
		biased = v ^ 16'h8000;
		q0     = biased[15:8];
		prod   = {1'b0, q0, 8'h00} + {9'b0, q0};
		if (prod > {1'b0, biased}) begin
			return q0 - 8'd1;
		end
		return q0;
	endfunction

	function automatic logic [7:0] frame_byte(input logic [3:0] fi, input ajpe_row_t r);
		logic [7:0] b;
		b = 8'h00;
		case (fi)
			4'd0:    b = {4'h9, ~r.btn[7], ~r.btn[6], ~r.btn[5], ~r.btn[4]};
			4'd1:    b = {4'hB, ~r.btn[3:0]};
			4'd2:    b = {4'h9, r.sy[7:4]};
			4'd3:    b = {4'hB, r.sx[7:4]};
			4'd4:    b = {4'h9, r.sz[7:4]};
			4'd5:    b = 8'hBF;
			4'd6:    b = {4'h9, r.sy[3:0]};
			4'd7:    b = {4'hB, r.sx[3:0]};
			4'd8:    b = {4'h9, r.sz[3:0]};
			4'd9:    b = 8'hBF;
			4'd10:   b = {4'h9, ~r.btn[7], ~r.btn[6], 2'b11};
			4'd11:   b = 8'hBF;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

FILE: hdl/ajpe_ram.sv
`timescale 1ns / 1ps

module ajpe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: hdl/analog_joystick_port_emulator_core.sv
`timescale 1ns / 1ps

// Two-port joystick interface with a digital mode and an analog handshake mode on
// port 0. Every input word (a port read, a port write, a pad update or an unused
// mode) gives exactly one result word (read byte in bits 7:0, analog flag in bit 8).
// One word is taken per cycle while the result side does not stall; the word is
// registered in stage 1 while the port's row (select latch, pad bytes, frame sources)
// is read from a 2-entry RAM, and the row is then updated and written back as the
// result is registered, with the last write forwarded to the next word. Only a stall
// on the result side holds the input. Per-row valid bits give the reset contents, so
// there is no clearing pass after reset. The config port is always ready.
module analog_joystick_port_emulator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// mode
	input  logic [ajpe_pkg::USER_W-1:0] s_tuser,
	// port, write_data, now_us, pad_low, pad_high, axis_x, axis_y, axis_z,
	// analog_buttons, key_mask
	input  logic [ajpe_pkg::IN_W-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// read_data, analog_active
	output logic [ajpe_pkg::OUT_W-1:0]  m_tdata,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [2:0]                  cfg_index,
	input  logic [15:0]                 cfg_data
);

	import ajpe_pkg::*;

	// configuration
	logic [1:0]  joy_mode_q;
	logic        ovl_en_q;
	logic        ovl_port_q;
	logic [1:0]  port_en_q;
	logic [9:0]  idle_limit_q;
	logic [9:0]  detect_min_q;
	logic [15:0] start_delay_q;

	// scalar state
	logic        an_q;
	logic [9:0]  rc_q;
	logic [3:0]  fi_q;
	logic [3:0]  ph_q;
	logic [31:0] edge_q;
	logic [7:0]  ovl_q;
	logic [1:0]  vld_q;
	logic        byp_valid_q;
	logic        byp_addr_q;
	ajpe_row_t   byp_row_q;

	// stage 1
	logic        v_s1;
	logic [1:0]  mode_s1;
	logic        port_s1;
	logic [7:0]  wdata_s1;
	logic [31:0] now_s1;
	logic [7:0]  pad_low_s1;
	logic [7:0]  pad_high_s1;
	logic [15:0] ax_s1;
	logic [15:0] ay_s1;
	logic [15:0] az_s1;
	logic [7:0]  btn_s1;
	logic [7:0]  key_s1;

	logic [OUT_W-1:0] m_tdata_q;
	logic             m_tvalid_q;

	logic             accept;
	logic             adv;
	logic [ROW_W-1:0] ram_rd;
	ajpe_row_t        row_rd;
	ajpe_row_t        row_wr;
	logic             wr_en;

	logic        an_d;
	logic [9:0]  rc_d;
	logic [3:0]  fi_d;
	logic [3:0]  ph_d;
	logic [31:0] edge_d;
	logic [7:0]  ovl_d;
	logic [7:0]  rd;
	logic [9:0]  rc_inc;
	logic [7:0]  fb;
	logic [31:0] dif;
	logic [7:0]  r0;
	logic [7:0]  r1;

	assign adv      = v_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !v_s1 || adv;
	assign accept   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	ajpe_ram #(
		.WIDTH(ROW_W),
		.DEPTH(2)
	) u_row_ram (
		.clk    (clk),
		.wr_en  (adv && wr_en),
		.wr_addr(port_s1),
		.wr_data(row_wr),
		.rd_en  (accept),
		.rd_addr(s_tdata[0]),
		.rd_data(ram_rd)
	);

	// forward the latest write, else RAM, else reset contents
	always_comb begin
		if (byp_valid_q && byp_addr_q == port_s1) begin
			row_rd = byp_row_q;
		end else if (vld_q[port_s1]) begin
			row_rd = ajpe_row_t'(ram_rd);
		end else begin
			row_rd = ROW_RESET;
		end
	end

	always_comb begin
		an_d   = an_q;
		rc_d   = rc_q;
		fi_d   = fi_q;
		ph_d   = ph_q;
		edge_d = edge_q;
		ovl_d  = ovl_q;
		row_wr = row_rd;
		wr_en  = 1'b0;
		rd     = 8'h00;
		rc_inc = (rc_q < idle_limit_q) ? rc_q + 10'd1 : rc_q;
		fb     = frame_byte(fi_q, row_rd);
		dif    = (now_s1 >= edge_q) ? now_s1 - edge_q : now_s1 - edge_q - 32'd1;
		r0     = port_en_q[port_s1] ? row_rd.pad_low : 8'hFF;
		r1     = port_en_q[port_s1] ? row_rd.pad_high : 8'hFF;
		if (ovl_en_q && ovl_port_q == port_s1) begin
			r0 = r0 ^ ovl_q;
		end
		case (mode_s1)
			MODE_READ: begin
				if (!port_s1) begin
					case (joy_mode_q)
						JOY_DIGITAL: an_d = 1'b0;
						JOY_ANALOG:  an_d = 1'b1;
						JOY_AUTO: begin
							rc_d = rc_inc;
							if (rc_inc >= idle_limit_q) begin
								an_d = 1'b0;
							end
						end
						default: ;
					endcase
				end
				if (!port_s1 && an_d) begin
					rd = IDLE_BYTE;
					case (ph_q) inside
						PH_DELAY: begin
							if (dif > {16'h0000, start_delay_q}) begin
								ph_d = PH_LEAD_A;
							end
						end
						PH_LEAD_A, PH_LEAD_B: begin
							rd   = fb | ACK_BIT;
							ph_d = ph_q + 4'd1;
						end
						PH_DATA_A, PH_DATA_B, PH_GAP: begin
							rd   = fb;
							ph_d = ph_q + 4'd1;
						end
						PH_TAIL_A, PH_TAIL_B: begin
							rd   = fb | ACK_BIT;
							ph_d = ph_q + 4'd1;
							fi_d = fi_q + 4'd1;
						end
						default: begin
							if (fi_q < FRAME_END) begin
								rd   = fb;
								ph_d = PH_LEAD_A;
							end
						end
					endcase
				end else begin
					rd = (~row_rd.sel & r0) | (row_rd.sel & r1);
				end
			end
			MODE_WRITE: begin
				if (!port_s1 && row_rd.sel == SEL_ALL && wdata_s1 == 8'h00) begin
					an_d   = rc_q > detect_min_q;
					rc_d   = 10'd0;
					fi_d   = 4'd0;
					ph_d   = PH_DELAY;
					edge_d = now_s1;
				end
				row_wr.sel = wdata_s1;
				wr_en      = 1'b1;
			end
			MODE_PAD: begin
				row_wr.pad_low  = pad_low_s1;
				row_wr.pad_high = pad_high_s1;
				ovl_d           = key_s1;
				if (!port_s1) begin
					row_wr.btn = btn_s1;
					row_wr.sx  = scale_axis(ax_s1);
					row_wr.sy  = scale_axis(ay_s1);
					row_wr.sz  = scale_axis(az_s1);
				end
				wr_en = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joy_mode_q    <= JOY_DIGITAL;
			ovl_en_q      <= 1'b0;
			ovl_port_q    <= 1'b0;
			port_en_q     <= 2'd1;
			idle_limit_q  <= 10'd1000;
			detect_min_q  <= 10'd300;
			start_delay_q <= 16'd40;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_JOY_MODE:    joy_mode_q    <= cfg_data[1:0];
				CFG_OVL_ENABLE:  ovl_en_q      <= cfg_data[0];
				CFG_OVL_PORT:    ovl_port_q    <= cfg_data[0];
				CFG_PORT_ENABLE: port_en_q     <= cfg_data[1:0];
				CFG_IDLE_LIMIT:  idle_limit_q  <= cfg_data[9:0];
				CFG_DETECT_MIN:  detect_min_q  <= cfg_data[9:0];
				CFG_START_DELAY: start_delay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			m_tvalid_q  <= 1'b0;
			an_q        <= 1'b0;
			rc_q        <= 10'd0;
			fi_q        <= 4'd0;
			ph_q        <= PH_DELAY;
			edge_q      <= 32'd0;
			ovl_q       <= 8'h00;
			vld_q       <= 2'b00;
			byp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (adv) begin
				an_q   <= an_d;
				rc_q   <= rc_d;
				fi_q   <= fi_d;
				ph_q   <= ph_d;
				edge_q <= edge_d;
				ovl_q  <= ovl_d;
				if (wr_en) begin
					vld_q[port_s1] <= 1'b1;
					byp_valid_q    <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1     <= s_tuser;
			port_s1     <= s_tdata[0];
			wdata_s1    <= s_tdata[8:1];
			now_s1      <= s_tdata[40:9];
			pad_low_s1  <= s_tdata[48:41];
			pad_high_s1 <= s_tdata[56:49];
			ax_s1       <= s_tdata[72:57];
			ay_s1       <= s_tdata[88:73];
			az_s1       <= s_tdata[104:89];
			btn_s1      <= s_tdata[112:105];
			key_s1      <= s_tdata[120:113];
		end
		if (adv) begin
			m_tdata_q <= {7'b0, an_d, rd};
			if (wr_en) begin
				byp_addr_q <= port_s1;
				byp_row_q  <= row_wr;
			end
		end
	end

endmodule

FILE: hdl/ajpe_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ajpe_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [ajpe_pkg::OUT_W-1:0] m_tdata
);

	// result word only carries 9 meaningful bits
	`AJPE_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[15:9] == 7'b0)

	// a fresh result comes from an accepted word, registered in stage 1 and then as the result
	`AJPE_ASSERT_NOW(a_rise_from_accept, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

	// a stalled result holds
	`AJPE_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind analog_joystick_port_emulator_core ajpe_checker u_ajpe_checker (.*);

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ajpe_pkg::*;

	localparam int STUCK_LIMIT = 4000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 120;

	typedef struct packed {
		logic [7:0]  key_mask;
		logic [7:0]  buttons;
		logic [15:0] axis_z;
		logic [15:0] axis_y;
		logic [15:0] axis_x;
		logic [7:0]  pad_high;
		logic [7:0]  pad_low;
		logic [31:0] now_us;
		logic [7:0]  write_data;
		logic        port;
		logic [1:0]  mode;
	} joy_item_t;

	typedef struct packed {
		logic       analog;
		logic [7:0] read_data;
	} joy_result_t;

	// Tracks the port state and predicts the result word of every accepted input word.
	class joystick_predictor;
		logic [1:0]  joy_mode;
		logic        ovl_en, ovl_port;
		logic [1:0]  port_en;
		logic [9:0]  idle_limit, detect_min;
		logic [15:0] start_delay;

		logic [7:0]  sel[2], pad_lo[2], pad_hi[2];
		logic [7:0]  ovl_mask;
		logic [7:0]  frame[13];
		logic        analog_on;
		int unsigned read_cnt, frame_idx;
		logic [3:0]  phase;
		logic [31:0] edge_us;

		joy_result_t predicted_words[$];
		int          errors;

		function new();
			errors = 0;
			joy_mode = JOY_DIGITAL;
			ovl_en = 0;
			ovl_port = 0;
			port_en = 2'd1;
			idle_limit = 10'd1000;
			detect_min = 10'd300;
			start_delay = 16'd40;
			sel = '{8'h00, 8'h00};
			pad_lo = '{8'hFF, 8'hFF};
			pad_hi = '{8'hFF, 8'hFF};
			ovl_mask = 8'h00;
			frame = '{8'h9F, 8'hBF, 8'h97, 8'hB7, 8'h97, 8'hB7, 8'h9F, 8'hBF,
				8'h9F, 8'hBF, 8'h9F, 8'hBF, 8'h00};
			analog_on = 0;
			read_cnt = 0;
			frame_idx = 0;
			phase = PH_DELAY;
			edge_us = '0;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 200) $display("ERROR at %0t: %s", $time, msg);
		endtask

		function void set_config(logic [2:0] idx, logic [15:0] v);
			case (idx)
				CFG_JOY_MODE:    joy_mode = v[1:0];
				CFG_OVL_ENABLE:  ovl_en = v[0];
				CFG_OVL_PORT:    ovl_port = v[0];
				CFG_PORT_ENABLE: port_en = v[1:0];
				CFG_IDLE_LIMIT:  idle_limit = v[9:0];
				CFG_DETECT_MIN:  detect_min = v[9:0];
				CFG_START_DELAY: start_delay = v;
				default: ;
			endcase
		endfunction

		function logic [7:0] axis_byte(logic [15:0] v);
			logic [31:0] biased;
			biased = {16'h0, v ^ 16'h8000};
			return 8'((biased * 32'd255) / 32'd65535);
		endfunction

		function void load_frame(joy_item_t it);
			logic [7:0] x, y, z, b, f0, f1, f10;
			b = it.buttons;
			x = axis_byte(it.axis_x);
			y = axis_byte(it.axis_y);
			z = axis_byte(it.axis_z);
			f0 = 8'h9F;
			f1 = 8'hBF;
			f10 = 8'h9F;
			if (b[7]) begin
				f0 &= 8'hF7;
				f10 &= 8'hF7;
			end
			if (b[6]) begin
				f0 &= 8'hFB;
				f10 &= 8'hFB;
			end
			if (b[5]) f0 &= 8'hFD;
			if (b[4]) f0 &= 8'hFE;
			if (b[3]) f1 &= 8'hF7;
			if (b[2]) f1 &= 8'hFB;
			if (b[1]) f1 &= 8'hFD;
			if (b[0]) f1 &= 8'hFE;
			frame[0] = f0;
			frame[1] = f1;
			frame[2] = {4'h9, y[7:4]};
			frame[3] = {4'hB, x[7:4]};
			frame[4] = {4'h9, z[7:4]};
			frame[5] = 8'hBF;
			frame[6] = {4'h9, y[3:0]};
			frame[7] = {4'hB, x[3:0]};
			frame[8] = {4'h9, z[3:0]};
			frame[9] = 8'hBF;
			frame[10] = f10;
			frame[11] = 8'hBF;
		endfunction

		function logic [7:0] frame_at();
			return frame[(frame_idx <= FRAME_BYTES) ? frame_idx : FRAME_BYTES];
		endfunction

		function logic [7:0] handshake_read(logic [31:0] now);
			logic [7:0]  ret;
			logic [31:0] dif;
			ret = IDLE_BYTE;
			case (phase)
				PH_DELAY: begin
					// elapsed time wraps through the top of the counter
					if (now >= edge_us) dif = now - edge_us;
					else dif = 32'hFFFF_FFFF - edge_us + now;
					if (dif > {16'h0, start_delay}) phase = PH_LEAD_A;
				end
				PH_LEAD_A, PH_LEAD_B: begin
					ret = frame_at() | ACK_BIT;
					phase = phase + 4'd1;
				end
				PH_DATA_A, PH_DATA_B, PH_GAP: begin
					ret = frame_at();
					phase = phase + 4'd1;
				end
				PH_TAIL_A, PH_TAIL_B: begin
					ret = frame_at() | ACK_BIT;
					phase = phase + 4'd1;
					frame_idx++;
				end
				default: begin
					if (frame_idx < FRAME_BYTES) begin
						ret = frame_at();
						phase = PH_LEAD_A;
					end
				end
			endcase
			return ret;
		endfunction

		function logic [7:0] port_read(logic p, logic [31:0] now);
			logic [7:0] lo, hi;
			lo = 8'hFF;
			hi = 8'hFF;
			if (!p) begin
				if (joy_mode == JOY_DIGITAL) analog_on = 0;
				else if (joy_mode == JOY_ANALOG) analog_on = 1;
				else if (joy_mode == JOY_AUTO) begin
					if (read_cnt < idle_limit) read_cnt++;
					if (read_cnt >= idle_limit) analog_on = 0;
				end
				if (analog_on) return handshake_read(now);
			end
			if (port_en[p]) begin
				lo = pad_lo[p];
				hi = pad_hi[p];
			end
			if (ovl_en && ovl_port == p) lo ^= ovl_mask;
			return (~sel[p] & lo) | (sel[p] & hi);
		endfunction

		function void take_item(joy_item_t it);
			joy_result_t r;
			r.read_data = 8'h00;
			case (it.mode)
				MODE_READ: r.read_data = port_read(it.port, it.now_us);
				MODE_WRITE: begin
					// falling edge of the port 0 latch starts a handshake
					if (!it.port && sel[0] == SEL_ALL && it.write_data == 8'h00) begin
						analog_on = (read_cnt > detect_min);
						read_cnt = 0;
						frame_idx = 0;
						phase = PH_DELAY;
						edge_us = it.now_us;
					end
					sel[it.port] = it.write_data;
				end
				MODE_PAD: begin
					pad_lo[it.port] = it.pad_low;
					pad_hi[it.port] = it.pad_high;
					ovl_mask = it.key_mask;
					if (!it.port) load_frame(it);
				end
				default: ;
			endcase
			r.analog = analog_on;
			predicted_words.push_back(r);
		endfunction

		task check_word(logic [15:0] w);
			joy_result_t e;
			if (predicted_words.size() == 0) begin
				report($sformatf("result word %h with nothing expected", w));
				return;
			end
			e = predicted_words.pop_front();
			if (w[7:0] !== e.read_data)
				report($sformatf("read_data %h, expected %h", w[7:0], e.read_data));
			if (w[8] !== e.analog)
				report($sformatf("analog_active %b, expected %b", w[8], e.analog));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [USER_W-1:0] s_tuser;
	logic [IN_W-1:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	joystick_predictor pred;
	logic        quiet;
	logic [31:0] clock_us;
	int          cfg_detect;
	int          items_sent;
	int          stuck;

	analog_joystick_port_emulator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				pred.take_item(joy_item_t'({s_tdata[$bits(joy_item_t)-USER_W-1:0], s_tuser}));
			if (m_tvalid && m_tready) pred.check_word(m_tdata);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			stuck = 0;
		end else begin
			stuck++;
			if (stuck >= STUCK_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", STUCK_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// result side: random stall bursts unless quiet
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 6) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11) - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic logic [15:0] rand_axis();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic joy_item_t rand_item();
		joy_item_t    it;
		logic [127:0] raw;
		raw = {$urandom(), $urandom(), $urandom(), $urandom()};
		it = raw[$bits(joy_item_t)-1:0];
		it.mode = 2'($urandom_range(0, 3));
		return it;
	endfunction

	task send_item(input joy_item_t it);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11) - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= it.mode;
		s_tdata <= {{(IN_W - $bits(joy_item_t) + USER_W){1'b0}},
			it[$bits(joy_item_t)-1:USER_W]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	// item on the running microsecond clock, with random payload
	task send_port(input logic [1:0] mode, input logic port, input logic [7:0] data);
		joy_item_t it;
		it = rand_item();
		it.mode = mode;
		it.port = port;
		it.write_data = data;
		it.now_us = clock_us;
		if (mode == MODE_PAD) begin
			it.axis_x = rand_axis();
			it.axis_y = rand_axis();
			it.axis_z = rand_axis();
		end
		clock_us = clock_us + $urandom_range(0, 15);
		send_item(it);
	endtask

	task wait_drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pred.predicted_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task write_reg(input logic [2:0] idx, input logic [15:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		pred.set_config(idx, v);
	endtask

	task set_regs(input logic [1:0] joy, input logic oen, input logic oport,
			input logic [1:0] pen, input logic [9:0] idle, input logic [9:0] detect,
			input logic [15:0] delay);
		write_reg(CFG_JOY_MODE, {14'h0, joy});
		write_reg(CFG_OVL_ENABLE, {15'h0, oen});
		write_reg(CFG_OVL_PORT, {15'h0, oport});
		write_reg(CFG_PORT_ENABLE, {14'h0, pen});
		write_reg(CFG_IDLE_LIMIT, {6'h0, idle});
		write_reg(CFG_DETECT_MIN, {6'h0, detect});
		write_reg(CFG_START_DELAY, delay);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_detect = detect;
	endtask

	task run_directed();
		joy_item_t it;
		// reset contents, both ports
		send_port(MODE_READ, 1'b0, 8'h00);
		send_port(MODE_READ, 1'b1, 8'h00);
		it = rand_item();
		it.mode = MODE_PAD;
		it.port = 1'b0;
		it.pad_low = 8'h00;
		it.pad_high = 8'hFF;
		it.axis_x = 16'h7FFF;
		it.axis_y = 16'h8000;
		it.axis_z = 16'h0000;
		it.buttons = 8'hFF;
		it.key_mask = 8'hAA;
		send_item(it);
		it.port = 1'b1;
		it.pad_low = 8'h55;
		it.pad_high = 8'hAA;
		it.buttons = 8'h00;
		it.key_mask = 8'h00;
		send_item(it);
		send_port(MODE_WRITE, 1'b0, 8'h3C);
		send_port(MODE_READ, 1'b0, 8'h00);
		send_port(MODE_WRITE, 1'b1, 8'hC3);
		send_port(MODE_READ, 1'b1, 8'h00);
		it = '1;
		send_item(it);
		wait_drain();

		// forced analog, overlay on port 1, handshake across the timestamp wrap
		set_regs(JOY_ANALOG, 1'b1, 1'b1, 2'd3, 10'd1023, 10'd1023, 16'd0);
		send_port(MODE_PAD, 1'b0, 8'h00);
		send_port(MODE_READ, 1'b1, 8'h00);
		send_port(MODE_WRITE, 1'b0, 8'hFF);
		clock_us = 32'hFFFF_FFF0;
		send_port(MODE_WRITE, 1'b0, 8'h00);
		clock_us = 32'd5;
		repeat (4) send_port(MODE_READ, 1'b0, 8'h00);
		wait_drain();

		// automatic mode with a zero idle limit stays digital
		set_regs(JOY_AUTO, 1'b0, 1'b0, 2'd1, 10'd0, 10'd0, 16'd0);
		send_port(MODE_READ, 1'b0, 8'h00);
		wait_drain();

		// analog chosen by a write in digital mode, then dropped by the next read
		set_regs(JOY_AUTO, 1'b0, 1'b0, 2'd1, 10'd1023, 10'd0, 16'd0);
		repeat (2) send_port(MODE_READ, 1'b0, 8'h00);
		wait_drain();
		set_regs(JOY_DIGITAL, 1'b0, 1'b0, 2'd1, 10'd1023, 10'd0, 16'd0);
		send_port(MODE_WRITE, 1'b0, 8'hFF);
		send_port(MODE_WRITE, 1'b0, 8'h00);
		send_port(MODE_READ, 1'b0, 8'h00);
	endtask

	task run_handshake();
		int pre, post;
		if ($urandom_range(0, 1)) send_port(MODE_PAD, 1'b0, 8'h00);
		send_port(MODE_WRITE, 1'b0, 8'hFF);
		if (cfg_detect < 40) pre = cfg_detect + int'($urandom_range(0, 4)) - 1;
		else pre = $urandom_range(0, 20);
		if (pre < 0) pre = 0;
		repeat (pre) begin
			if ($urandom_range(0, 9) == 0) send_port(MODE_READ, 1'b1, 8'h00);
			send_port(MODE_READ, 1'b0, 8'h00);
		end
		if ($urandom_range(0, 7) == 0) clock_us = 32'hFFFF_FFFF - $urandom_range(0, 40);
		send_port(MODE_WRITE, 1'b0, 8'h00);
		post = $urandom_range(10, 60);
		repeat (post) begin
			case ($urandom_range(0, 19))
				0: send_port(MODE_PAD, 1'b0, 8'h00);
				1: send_port(MODE_READ, 1'b1, 8'h00);
				default: send_port(MODE_READ, 1'b0, 8'h00);
			endcase
		end
	endtask

	task run_digital();
		logic [7:0] d;
		repeat ($urandom_range(3, 10)) begin
			case ($urandom_range(0, 3))
				0: d = 8'hFF;
				1: d = 8'h00;
				default: d = 8'($urandom());
			endcase
			send_port(2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)), d);
		end
	endtask

	initial begin
		int ph, stop_at;
		pred = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = '0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_JOY_MODE;
		cfg_data = '0;
		quiet = 1'b0;
		clock_us = '0;
		cfg_detect = 300;
		items_sent = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();

		for (ph = 0; ph < PHASES; ph++) begin
			wait_drain();
			quiet = (ph == PHASES - 1);
			if (ph == 0) begin
				set_regs(JOY_AUTO, 1'b1, 1'b1, 2'd3, 10'd1023, 10'd1023, 16'hFFFF);
			end else if (ph == 1) begin
				set_regs(JOY_DIGITAL, 1'b0, 1'b0, 2'd0, 10'd1, 10'd0, 16'd0);
			end else begin
				set_regs(
					($urandom_range(0, 9) < 6) ? JOY_AUTO :
					($urandom_range(0, 3) < 2) ? JOY_ANALOG :
					($urandom_range(0, 1) == 0) ? JOY_DIGITAL : 2'd3,
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					2'($urandom_range(0, 3)),
					($urandom_range(0, 3) == 0) ? 10'($urandom_range(1, 1023))
						: 10'($urandom_range(40, 150)),
					($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
						: 10'($urandom_range(0, 25)),
					($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 65535))
						: 16'($urandom_range(0, 60)));
			end
			stop_at = items_sent + PHASE_ITEMS;
			while (items_sent < stop_at) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: run_handshake();
					6, 7: run_digital();
					default: repeat ($urandom_range(1, 3)) send_item(rand_item());
				endcase
				// hold off until the block has emptied
				if (!quiet && $urandom_range(0, 15) == 0) wait_drain();
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pred.predicted_words.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (pred.predicted_words.size() != 0)
			pred.report($sformatf("%0d results never arrived", pred.predicted_words.size()));
		if (pred.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
